[design/mdt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types and constants for the measurement dedup table.
// ----------------------------------------------------------------------------
package mdt_pkg;

    localparam logic [1:0]  REQ_UPDATE  = 2'd0;
    localparam logic [1:0]  REQ_CLEAR   = 2'd1;
    localparam logic [1:0]  REQ_DUMP    = 2'd2;

    localparam logic [30:0] FLOOR_RESET = 31'd1680000000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        node_id;
        logic [31:0]        path;
        logic [63:0]        device_addr;
        logic signed [31:0] stamp;
        logic [31:0]        reading;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic        matched;
        logic        entry_valid;
        logic [63:0] entry_node;
        logic [31:0] entry_path;
        logic [63:0] entry_addr;
        logic [30:0] entry_stamp;
        logic [31:0] entry_reading;
        logic        last;
    } t_rsp;

    // one table slot: key triple plus stored data
    typedef struct packed {
        logic [63:0] node;
        logic [31:0] path;
        logic [63:0] addr;
        logic [30:0] stamp;
        logic [31:0] reading;
    } t_entry;

    // memory request from the sequencer, address carried separately
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

[design/mdt_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_store
// Entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mdt_store #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5
) (
    input  logic                  i_clk,
    input  mdt_pkg::t_mem_ctl     i_ctl,
    input  logic [IDX_W-1:0]      i_rd_addr,
    output mdt_pkg::t_entry       o_rd_data,
    input  logic [IDX_W-1:0]      i_wr_addr,
    input  mdt_pkg::t_entry       i_wr_data
);

    mdt_pkg::t_entry r_mem [TABLE_DEPTH];
    mdt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mdt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdt_ctrl
// Request sequencer: serial key search with one shared comparator, append,
// clear and dump walk.
// ----------------------------------------------------------------------------
module mdt_ctrl #(
    parameter int TABLE_DEPTH = 32,
    parameter int IDX_W       = 5,
    parameter int CNT_W       = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mdt_pkg::t_req      i_in_data,
    input  logic [30:0]        i_time_floor,
    input  logic               i_out_free,
    output logic               o_push,
    output mdt_pkg::t_rsp      o_rsp,
    output mdt_pkg::t_mem_ctl  o_mem_ctl,
    output logic [IDX_W-1:0]   o_rd_addr,
    input  mdt_pkg::t_entry    i_rd_data,
    output logic [IDX_W-1:0]   o_wr_addr,
    output mdt_pkg::t_entry    o_wr_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_RESP   = 3'd3;
    localparam logic [2:0] S_DRD    = 3'd4;
    localparam logic [2:0] S_DOUT   = 3'd5;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic [CNT_W-1:0] r_slot,  n_slot;
    logic             r_pend,  n_pend;
    logic             r_append, n_append;
    mdt_pkg::t_entry  r_req,   n_req;
    mdt_pkg::t_rsp    r_rsp,   n_rsp;

    logic             accept;
    logic             above;
    logic             key_eq;
    logic             dump_last;
    mdt_pkg::t_rsp    dump_rsp;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // signed stamp: above the floor only when positive and strictly greater
    assign above  = !i_in_data.stamp[31] && (i_in_data.stamp[30:0] > i_time_floor);

    // shared key comparator against the registered memory word
    assign key_eq = (i_rd_data.path == r_req.path) && (i_rd_data.addr == r_req.addr)
                 && (i_rd_data.node == r_req.node);

    assign dump_last = ((r_idx + ONE_C) == r_count);

    always_comb begin
        dump_rsp               = '0;
        dump_rsp.accepted      = 1'b1;
        dump_rsp.entry_valid   = 1'b1;
        dump_rsp.entry_node    = i_rd_data.node;
        dump_rsp.entry_path    = i_rd_data.path;
        dump_rsp.entry_addr    = i_rd_data.addr;
        dump_rsp.entry_stamp   = i_rd_data.stamp;
        dump_rsp.entry_reading = i_rd_data.reading;
        dump_rsp.last          = dump_last;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_slot    = r_slot;
        n_pend    = 1'b0;
        n_append  = r_append;
        n_req     = r_req;
        n_rsp     = r_rsp;
        o_mem_ctl = '0;
        o_rd_addr = r_idx[IDX_W-1:0];
        o_push    = 1'b0;
        o_rsp     = r_rsp;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req.node    = i_in_data.node_id;
                    n_req.path    = i_in_data.path;
                    n_req.addr    = i_in_data.device_addr;
                    n_req.stamp   = above ? i_in_data.stamp[30:0] : 31'd0;
                    n_req.reading = i_in_data.reading;
                    n_idx         = '0;
                    n_rsp         = '0;
                    n_rsp.last    = 1'b1;
                    unique case (i_in_data.req_type)
                        mdt_pkg::REQ_UPDATE: begin
                            if (r_count == '0) begin
                                n_slot   = '0;
                                n_append = 1'b1;
                                n_state  = S_WRITE;
                            end else begin
                                n_state  = S_SEARCH;
                            end
                        end
                        mdt_pkg::REQ_CLEAR: begin
                            n_count        = '0;
                            n_rsp.accepted = 1'b1;
                            n_state        = S_RESP;
                        end
                        mdt_pkg::REQ_DUMP: begin
                            if (r_count == '0) begin
                                n_rsp.accepted = 1'b1;
                                n_state        = S_RESP;
                            end else begin
                                n_state        = S_DRD;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_pend && key_eq) begin
                    n_slot   = r_idx - ONE_C;
                    n_append = 1'b0;
                    n_state  = S_WRITE;
                end else if (r_idx == r_count) begin
                    if (r_count < DEPTH_C) begin
                        n_slot   = r_count;
                        n_append = 1'b1;
                        n_state  = S_WRITE;
                    end else begin
                        n_state  = S_RESP;
                    end
                end else begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_idx           = r_idx + ONE_C;
                    n_pend          = 1'b1;
                end
            end
            S_WRITE: begin
                o_mem_ctl.wr_en = 1'b1;
                if (r_append) begin
                    n_count = r_count + ONE_C;
                end
                n_rsp.accepted = 1'b1;
                n_rsp.matched  = !r_append;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DRD: begin
                o_mem_ctl.rd_en = 1'b1;
                n_state         = S_DOUT;
            end
            S_DOUT: begin
                o_rsp = dump_rsp;
                if (i_out_free) begin
                    o_push  = 1'b1;
                    n_idx   = r_idx + ONE_C;
                    n_state = dump_last ? S_IDLE : S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_wr_addr = r_slot[IDX_W-1:0];
    assign o_wr_data = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_slot   <= n_slot;
        r_append <= n_append;
        r_req    <= n_req;
        r_rsp    <= n_rsp;
    end

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> i_out_free)
        else $error("result pushed into a full output register");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("fill count above table depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.req_type == mdt_pkg::REQ_CLEAR) |=> (r_count == '0))
        else $error("clear left entries in the table");

    a_wr_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> (r_slot <= r_count && r_slot < DEPTH_C))
        else $error("write outside the filled region");

endmodule

[design/measurement_dedup_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// measurement_dedup_table
// Bounded insert-or-update table of measurements keyed by node, path and
// device address, with clear and dump requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; o_in_stall stays high until its last
// result has been handed to the output register. The key search reads one
// slot per cycle through the single memory read port and one shared
// comparator. From the accepting edge to the edge that loads the output
// register, with the result channel free, the steps are:
// - update on an empty table: write, then hand-over;
// - update that misses a table holding fill_count entries: one read per
//   entry plus a final compare, then write and hand-over;
// - update that misses a full table: the same reads and compare, then
//   hand-over, as nothing is written;
// - update that hits slot k: reads up to slot k, then write and hand-over;
// - clear, unknown request or dump of an empty table: hand-over only;
// - dump: per filled entry, a read, then hand-over.
// A stalled result channel adds its stall cycles at each hand-over.
// The output register lets a finished result wait while the sequencer
// returns to idle. time_floor may be written only while the block is idle.
// There is no clearing pass: only slots below the fill count are ever read.
// ----------------------------------------------------------------------------
module measurement_dedup_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // request channel
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mdt_pkg::t_req  i_in_data,
    // result channel
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mdt_pkg::t_rsp  o_out_data,
    // time_floor register
    input  logic           i_cfg_wr_en,
    input  logic [30:0]    i_cfg_wr_data
);

    // index needs at least one bit; counter must hold the depth itself
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [30:0]        r_time_floor;
    logic               r_out_vld;
    mdt_pkg::t_rsp      r_out;

    logic               out_free;
    logic               push;
    mdt_pkg::t_rsp      rsp;
    mdt_pkg::t_mem_ctl  mem_ctl;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    mdt_pkg::t_entry    rd_data;
    mdt_pkg::t_entry    wr_data;

    // floor register, reset to the deployment default
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_floor <= mdt_pkg::FLOOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_time_floor <= i_cfg_wr_data;
        end
    end

    // output register: free when empty or being transferred this cycle
    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    mdt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_time_floor (r_time_floor),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_rsp        (rsp),
        .o_mem_ctl    (mem_ctl),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    mdt_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for measurement_dedup_table. A scoreboard class keeps
// its own copy of the table and the time floor, predicts the results of
// each accepted request, and checks every result transfer in order.
// Stimulus is a directed opening, then four random phases. Each phase runs
// with its own time floor and its own mix of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          DEPTH         = 32;
    localparam int          POOL          = 8;     // keys reused to force hits
    localparam int          PHASE_ITEMS   = 23;
    localparam int          SETTLE_CYCLES = 40;    // > full-table update latency
    localparam int          HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam logic [1:0]  REQ_UNKNOWN   = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: private table model plus the queue of awaited results
    // ------------------------------------------------------------------------
    class table_scoreboard;
        mdt_pkg::t_entry slots [DEPTH];
        int unsigned     fill;
        logic [30:0]     time_floor;
        mdt_pkg::t_rsp   awaited [$];
        int              errors;

        function new();
            fill       = 0;
            time_floor = mdt_pkg::FLOOR_RESET;
            errors     = 0;
        endfunction

        function void set_floor(logic [30:0] value);
            time_floor = value;
        endfunction

        // predict the result transfers caused by one accepted request
        function void note_request(mdt_pkg::t_req req);
            mdt_pkg::t_rsp rsp;
            logic [30:0]   st;
            bit            hit;
            rsp = '0;
            rsp.last = 1'b1;
            hit = 1'b0;
            case (req.req_type)
                mdt_pkg::REQ_UPDATE: begin
                    // negative stamps and stamps at or below the floor store as zero
                    st = (!req.stamp[31] && (req.stamp[30:0] > time_floor)) ?
                         req.stamp[30:0] : 31'd0;
                    for (int i = 0; i < fill; i++) begin
                        if (!hit && slots[i].node == req.node_id &&
                            slots[i].path == req.path && slots[i].addr == req.device_addr) begin
                            slots[i].stamp   = st;
                            slots[i].reading = req.reading;
                            hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        rsp.accepted = 1'b1;
                        rsp.matched  = 1'b1;
                    end else if (fill < DEPTH) begin
                        slots[fill] = '{req.node_id, req.path, req.device_addr,
                                        st, req.reading};
                        fill++;
                        rsp.accepted = 1'b1;
                    end
                    awaited.push_back(rsp);
                end
                mdt_pkg::REQ_CLEAR: begin
                    fill = 0;
                    rsp.accepted = 1'b1;
                    awaited.push_back(rsp);
                end
                mdt_pkg::REQ_DUMP: begin
                    rsp.accepted = 1'b1;
                    if (fill == 0) begin
                        awaited.push_back(rsp);
                    end else begin
                        for (int i = 0; i < fill; i++) begin
                            rsp.entry_valid   = 1'b1;
                            rsp.entry_node    = slots[i].node;
                            rsp.entry_path    = slots[i].path;
                            rsp.entry_addr    = slots[i].addr;
                            rsp.entry_stamp   = slots[i].stamp;
                            rsp.entry_reading = slots[i].reading;
                            rsp.last          = (i + 1 == fill);
                            awaited.push_back(rsp);
                        end
                    end
                end
                default: begin
                    // unknown type: ignored, lone result with only last set
                    awaited.push_back(rsp);
                end
            endcase
        endfunction

        function void cmp(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(mdt_pkg::t_rsp got);
            mdt_pkg::t_rsp want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result with none awaited, expected none, actual %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            cmp("accepted",      64'(want.accepted),      64'(got.accepted));
            cmp("matched",       64'(want.matched),       64'(got.matched));
            cmp("entry_valid",   64'(want.entry_valid),   64'(got.entry_valid));
            cmp("entry_node",    want.entry_node,         got.entry_node);
            cmp("entry_path",    64'(want.entry_path),    64'(got.entry_path));
            cmp("entry_addr",    want.entry_addr,         got.entry_addr);
            cmp("entry_stamp",   64'(want.entry_stamp),   64'(got.entry_stamp));
            cmp("entry_reading", 64'(want.entry_reading), 64'(got.entry_reading));
            cmp("last",          64'(want.last),          64'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic            i_clk         = 1'b0;
    logic            i_rst_n       = 1'b0;
    logic            i_in_valid    = 1'b0;
    logic            o_in_stall;
    mdt_pkg::t_req   i_in_data     = '0;
    logic            o_out_valid;
    logic            i_out_stall   = 1'b0;
    mdt_pkg::t_rsp   o_out_data;
    logic            i_cfg_wr_en   = 1'b0;
    logic [30:0]     i_cfg_wr_data = '0;

    table_scoreboard sb;

    int            send_idle_pct = 0;   // sender gap chance, percent per cycle
    int            stall_pct     = 0;   // receiver stall chance, percent per cycle
    bit            hold_req      = 1'b0;
    int            hold_left     = 0;

    logic [63:0]   pool_node [POOL];
    logic [31:0]   pool_path [POOL];
    logic [63:0]   pool_addr [POOL];

    measurement_dedup_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transfers are sampled on the rising edge; all driving happens on the
    // falling edge, so there is no ordering hazard within a time step.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_request(i_in_data);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
        end
    end

    // Receiver: random stalls, or a long hold-off counted down here so the
    // sender keeps offering while the block backs up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic mdt_pkg::t_req mk(logic [1:0] kind, logic [63:0] node,
                                         logic [31:0] path, logic [63:0] addr,
                                         logic [31:0] stamp, logic [31:0] value);
        mdt_pkg::t_req r;
        r.req_type    = kind;
        r.node_id     = node;
        r.path        = path;
        r.device_addr = addr;
        r.stamp       = stamp;
        r.reading     = value;
        return r;
    endfunction

    // stamps weighted towards the floor boundary and negative values
    function automatic logic [31:0] pick_stamp(logic [30:0] fl);
        case ($urandom_range(5))
            0:       return {1'b1, 31'($urandom)};
            1:       return {1'b0, fl};
            2:       return {1'b0, fl + 31'd1};
            3:       return {1'b0, fl - 31'd1};
            default: return $urandom;
        endcase
    endfunction

    function automatic mdt_pkg::t_req rand_req();
        mdt_pkg::t_req r;
        int            k;
        int            sel;
        r = mk(mdt_pkg::REQ_UPDATE, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
               pick_stamp(sb.time_floor), $urandom);
        sel = $urandom_range(99);
        if (sel < 78) begin
            // mostly pooled keys, so hits and refreshes are frequent
            if ($urandom_range(99) < 75) begin
                k = $urandom_range(POOL - 1);
                r.node_id     = pool_node[k];
                r.path        = pool_path[k];
                r.device_addr = pool_addr[k];
                // near miss: one key part borrowed from another pool key
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0:       r.node_id     = pool_node[(k + 1) % POOL];
                        1:       r.path        = pool_path[(k + 1) % POOL];
                        default: r.device_addr = pool_addr[(k + 1) % POOL];
                    endcase
                end
            end
        end else if (sel < 89) begin
            r.req_type = mdt_pkg::REQ_DUMP;
        end else if (sel < 96) begin
            r.req_type = mdt_pkg::REQ_CLEAR;
        end else begin
            r.req_type = REQ_UNKNOWN;
        end
        return r;
    endfunction

    task automatic refresh_pool();
        for (int i = 0; i < POOL; i++) begin
            pool_node[i] = {$urandom, $urandom};
            pool_path[i] = $urandom;
            pool_addr[i] = {$urandom, $urandom};
        end
    endtask

    // Called just after a falling edge; returns just after the falling edge
    // that follows the transfer. Valid is assigned once per time step.
    task automatic offer_request(mdt_pkg::t_req r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = r;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // sender pause until every awaited result has been transferred
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // block is idle here, so the model takes the new floor at once
    task automatic write_time_floor(logic [30:0] value);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        sb.set_floor(value);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    // clear, fill every slot, push past the limit, then dump the lot
    task automatic fill_to_full();
        mdt_pkg::t_req first;
        first = mk(mdt_pkg::REQ_UPDATE, {$urandom, $urandom}, $urandom,
                   {$urandom, $urandom}, pick_stamp(sb.time_floor), $urandom);
        offer_request(mk(mdt_pkg::REQ_CLEAR, '0, '0, '0, '0, '0));
        offer_request(first);
        for (int i = 1; i < DEPTH + 3; i++)
            offer_request(mk(mdt_pkg::REQ_UPDATE, {$urandom, $urandom}, $urandom,
                             {$urandom, $urandom}, pick_stamp(sb.time_floor), $urandom));
        // a hit still works on a full table
        offer_request(mk(mdt_pkg::REQ_UPDATE, first.node_id, first.path,
                         first.device_addr, '0, '0));
        offer_request(mk(mdt_pkg::REQ_DUMP, '0, '0, '0, '0, '0));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [30:0] floors [4];
        int          sender_mix [4];
        int          stall_mix [4];

        sb = new();
        refresh_pool();
        floors     = '{31'd0, 31'h7FFF_FFFF, 31'($urandom), mdt_pkg::FLOOR_RESET};
        sender_mix = '{0, 46, 0, 15};
        stall_mix  = '{0, 0, 46, 15};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed opening, reset floor, no idling
        offer_request(mk(mdt_pkg::REQ_DUMP, '1, '1, '1, '1, '1));    // dump of empty table
        offer_request(mk(mdt_pkg::REQ_UPDATE, '1, '1, '1, 32'h7FFF_FFFF, '1)); // largest
        offer_request(mk(mdt_pkg::REQ_UPDATE, '0, '0, '0, '0, '0));  // zero key, zero stamp
        offer_request(mk(mdt_pkg::REQ_UPDATE, 64'h0123_4567_89AB_CDEF, 32'hDEAD_BEEF,
                         64'hFEDC_BA98_7654_3210, 32'h8000_0000, 32'h1234_5678)); // most negative
        offer_request(mk(mdt_pkg::REQ_UPDATE, 64'h1, 32'h1, 64'h1,
                         {1'b0, mdt_pkg::FLOOR_RESET}, 32'hA5A5_A5A5)); // stamp on the floor
        offer_request(mk(mdt_pkg::REQ_UPDATE, 64'h2, 32'h2, 64'h2,
                         {1'b0, mdt_pkg::FLOOR_RESET + 31'd1},
                         32'h5A5A_5A5A));                            // just above the floor
        offer_request(mk(mdt_pkg::REQ_UPDATE, '1, '1, '1, 32'hFFFF_FFFF,
                         32'h0F0F_0F0F));                            // hit, -1
        offer_request(mk(mdt_pkg::REQ_UPDATE, '1, '1, '0, 32'h7000_0000, 32'h1)); // addr differs
        offer_request(mk(mdt_pkg::REQ_UPDATE, '0, '1, '1, 32'h7000_0001, 32'h2)); // node differs
        offer_request(mk(mdt_pkg::REQ_UPDATE, '1, '0, '1, 32'h7000_0002, 32'h3)); // path differs
        offer_request(mk(REQ_UNKNOWN, '1, '1, '1, '1, '1));          // unknown type
        offer_request(mk(mdt_pkg::REQ_DUMP, '0, '0, '0, '0, '0));
        offer_request(mk(mdt_pkg::REQ_UPDATE, 64'h1, 32'h1, 64'h1, 32'h7FFF_FFFE,
                         '0));                                       // hit, refresh
        offer_request(mk(mdt_pkg::REQ_DUMP, '0, '0, '0, '0, '0));
        offer_request(mk(mdt_pkg::REQ_CLEAR, '1, '1, '1, '1, '1));
        offer_request(mk(mdt_pkg::REQ_DUMP, '0, '0, '0, '0, '0));    // empty after clear
        offer_request(mk(REQ_UNKNOWN, '0, '0, '0, '0, '0));
        offer_request(mk(mdt_pkg::REQ_UPDATE, '0, '0, '0, 32'h7FFF_FFFF, '1));
        offer_request(mk(mdt_pkg::REQ_DUMP, '0, '0, '0, '0, '0));

        // random phases, each with its own floor and idling mix
        for (int p = 0; p < 4; p++) begin
            wait_for_results();
            write_time_floor(floors[p]);
            send_idle_pct = sender_mix[p];
            stall_pct     = stall_mix[p];
            refresh_pool();
            if (p == 1)
                fill_to_full();
            if (p == 3)
                hold_req = 1'b1;   // receiver backs off while requests keep coming
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_request(rand_req());
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_for_results();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
